// ----- design/tracker_event_decode_note_lookup_macros.svh -----
// Assertion macros for the tracker event decoder checker.
// Used only by the checker file; needs clk and rst_n in the including scope.
`ifndef TRACKER_EVENT_DECODE_NOTE_LOOKUP_MACROS_SVH
`define TRACKER_EVENT_DECODE_NOTE_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TEDNL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TEDNL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tednl_pkg.sv -----
// Shared types and constants for the tracker event decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package tednl_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [1:0] NOTE_FOUND   = 2'd0;
  localparam logic [1:0] NOTE_ZERO    = 2'd1;
  localparam logic [1:0] NOTE_NOMATCH = 2'd2;

  localparam logic REG_TRANSPOSE = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  typedef struct packed {
    logic        is_decode;
    logic [5:0]  table_index;
    logic [11:0] table_period;
    logic [4:0]  instrument_num;
    logic [3:0]  effect_code;
    logic [7:0]  effect_param;
    logic [11:0] period;
  } queue_entry_t;

  typedef struct packed {
    logic [4:0]        instrument_num;
    logic [3:0]        effect_code;
    logic [7:0]        effect_param;
    logic [11:0]       period;
    logic [1:0]        note_status;
    logic signed [7:0] note_index;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_COMPARE,
    BK_TOL_LO,
    BK_TOL_HI,
    BK_RESULT
  } back_state_t;

endpackage

`default_nettype wire

// ----- design/tednl_in_if.sv -----
// Input channel of the tracker event decoder: valid/ready plus item fields.
// No dependencies.
`default_nettype none

interface tednl_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [5:0]  table_index;
  logic [11:0] table_period;
  logic [31:0] event_word;

  modport source (output valid, mode, table_index, table_period, event_word,
                  input ready);
  modport sink (input valid, mode, table_index, table_period, event_word,
                output ready);
endinterface

`default_nettype wire

// ----- design/tednl_out_if.sv -----
// Result channel of the tracker event decoder: valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface tednl_out_if;
  logic              valid;
  logic              ready;
  logic [4:0]        instrument_num;
  logic [3:0]        effect_code;
  logic [7:0]        effect_param;
  logic [11:0]       period;
  logic [1:0]        note_status;
  logic signed [7:0] note_index;

  modport source (output valid, instrument_num, effect_code, effect_param, period,
                  note_status, note_index, input ready);
  modport sink (input valid, instrument_num, effect_code, effect_param, period,
                note_status, note_index, output ready);
endinterface

`default_nettype wire

// ----- design/tednl_front.sv -----
// Front end: accepts input words, splits events into fields, drops bad loads.
// Depends on tednl_pkg and tednl_in_if.
`default_nettype none

module tednl_front
  import tednl_pkg::*;
#(
  parameter int NOTE_COUNT = 64
) (
  tednl_in_if.sink     in_bus,
  input  wire logic    q_full,
  output queue_entry_t q_data,
  output logic         q_push
);

  logic [7:0] b0, b1, b2, b3;
  logic       load_ok;

  assign b0 = in_bus.event_word[31:24];
  assign b1 = in_bus.event_word[23:16];
  assign b2 = in_bus.event_word[15:8];
  assign b3 = in_bus.event_word[7:0];

  // A load beyond the table is accepted and then forgotten.
  assign load_ok = 9'(in_bus.table_index) < 9'(NOTE_COUNT);

  assign in_bus.ready = !q_full;

  always_comb begin
    q_data.is_decode      = (in_bus.mode == MODE_DECODE);
    q_data.table_index    = in_bus.table_index;
    q_data.table_period   = in_bus.table_period;
    q_data.instrument_num = {b0[4], b2[7:4]};
    q_data.effect_code    = b2[3:0];
    q_data.effect_param   = b3;
    q_data.period         = {b0[3:0], b1};
    q_push = in_bus.valid && !q_full && ((in_bus.mode == MODE_DECODE) || load_ok);
  end

endmodule

`default_nettype wire

// ----- design/tednl_queue.sv -----
// Short first-in first-out queue between the front and back ends.
// Depends on tednl_pkg.
`default_nettype none

module tednl_queue
  import tednl_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire queue_entry_t  push_data,
  input  wire logic          pop,
  output queue_entry_t       head,
  output logic               full,
  output logic               empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t   slot_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/tednl_back.sv -----
// Back end: period table memory, binary search sequencer and result register.
// Depends on tednl_pkg.
`default_nettype none

module tednl_back
  import tednl_pkg::*;
#(
  parameter int NOTE_COUNT = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire queue_entry_t       q_head,
  output logic                    q_pop,
  input  wire logic signed [6:0]  transpose,
  input  wire logic [5:0]         match_tolerance,
  output result_t                 res,
  output logic                    res_valid,
  input  wire logic               res_ready
);

  localparam int IW = $clog2(NOTE_COUNT);

  logic [11:0]   table_mem [NOTE_COUNT];
  logic [11:0]   rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;

  back_state_t   state_r, state_nxt;
  queue_entry_t  entry_r, entry_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [1:0]    status_r, status_nxt;
  result_t       out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [IW:0]       bound_sum;
  logic [IW-1:0]     mid;
  logic              span_gt1;
  logic              hit, above;
  logic              tol_lo_ok, tol_hi_ok;
  logic              out_free;
  logic signed [9:0] note_sum;
  logic signed [7:0] note_sat;

  assign bound_sum = (IW+1)'(lo_r) + (IW+1)'(hi_r);
  assign mid       = bound_sum[IW:1];
  assign span_gt1  = ((IW+1)'(hi_r) - (IW+1)'(lo_r)) > (IW+1)'(1);
  assign hit       = (rd_data_r == entry_r.period);
  assign above     = (rd_data_r > entry_r.period);
  // The low bracket passes when its entry minus the tolerance reaches the period.
  assign tol_lo_ok = 13'(rd_data_r) <= 13'(entry_r.period) + 13'(match_tolerance);
  assign tol_hi_ok = 13'(rd_data_r) + 13'(match_tolerance) >= 13'(entry_r.period);
  assign out_free  = !out_valid_r || res_ready;
  assign wr_addr   = IW'(q_head.table_index);

  assign note_sum = $signed({2'b00, 8'(idx_r)}) + 10'(transpose);
  always_comb begin
    if (note_sum > 10'sd127) begin
      note_sat = 8'sd127;
    end else if (note_sum < -10'sd128) begin
      note_sat = -8'sd128;
    end else begin
      note_sat = note_sum[7:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && q_head.is_decode) begin
          state_nxt = (q_head.period == '0) ? BK_RESULT : BK_SEARCH;
        end
      end
      BK_SEARCH:  state_nxt = span_gt1 ? BK_COMPARE : BK_TOL_LO;
      BK_COMPARE: state_nxt = hit ? BK_RESULT : BK_SEARCH;
      BK_TOL_LO:  state_nxt = tol_lo_ok ? BK_RESULT : BK_TOL_HI;
      BK_TOL_HI:  state_nxt = BK_RESULT;
      BK_RESULT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default:    state_nxt = BK_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    rd_addr       = lo_r;
    entry_nxt     = entry_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !res_ready;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          wr_en     = !q_head.is_decode;
          entry_nxt = q_head;
          lo_nxt    = '0;
          hi_nxt    = IW'(NOTE_COUNT - 1);
          idx_nxt   = '0;
          status_nxt = (q_head.period == '0) ? NOTE_ZERO : NOTE_FOUND;
        end
      end
      BK_SEARCH: begin
        rd_addr = span_gt1 ? mid : lo_r;
        mid_nxt = mid;
      end
      BK_COMPARE: begin
        if (hit) begin
          idx_nxt    = mid_r;
          status_nxt = NOTE_FOUND;
        end else if (above) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r;
        end
      end
      BK_TOL_LO: begin
        rd_addr = hi_r;
        if (tol_lo_ok) begin
          idx_nxt    = lo_r;
          status_nxt = NOTE_FOUND;
        end
      end
      BK_TOL_HI: begin
        if (tol_hi_ok) begin
          idx_nxt    = hi_r;
          status_nxt = NOTE_FOUND;
        end else begin
          status_nxt = NOTE_NOMATCH;
        end
      end
      BK_RESULT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.instrument_num = entry_r.instrument_num;
          out_nxt.effect_code    = entry_r.effect_code;
          out_nxt.effect_param   = entry_r.effect_param;
          out_nxt.period         = entry_r.period;
          out_nxt.note_status    = status_r;
          out_nxt.note_index     = (status_r == NOTE_FOUND) ? note_sat : 8'sd0;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r  <= entry_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= q_head.table_period;
    end
    rd_data_r <= table_mem[rd_addr];
  end

  assign res       = out_r;
  assign res_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- design/tracker_event_decode_note_lookup.sv -----
// Tracker pattern event decoder with period-to-note lookup. Each input word is
// either a table load (mode 0), which writes one entry of a descending period
// table and produces no result, or an event decode (mode 1), which produces one
// result: sample number, effect code, effect parameter, 12-bit period, and a
// note index found by binary search of the period table, offset by the signed
// transpose register. A period of zero reports status "period zero" without a
// table read; a period that misses the table by more than match_tolerance
// reports "no match". All table entries must be loaded before the first decode.
// Timing: the front end accepts one word per cycle while its two-word queue has room,
// so input words keep flowing while a result waits on the output until the queue
// fills. The back end takes a load in its idle state and runs a decode as a
// sequence of states: each search probe issues the address to the table memory
// and then compares its registered read data, followed by up to two tolerance
// reads and the result.
// Configuration writes take effect on the next cycle and must be made while
// the block is idle.
// Depends on tednl_pkg, tednl_in_if, tednl_out_if and the front, queue and
// back modules.
`default_nettype none

module tracker_event_decode_note_lookup
  import tednl_pkg::*;
#(
  parameter int NOTE_COUNT = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  tednl_in_if.sink        in_bus,
  tednl_out_if.source     out_bus,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data
);

  // Configuration registers.
  logic signed [6:0] transpose_r, transpose_nxt;
  logic [5:0]        tolerance_r, tolerance_nxt;

  queue_entry_t push_data, q_head;
  logic         q_push, q_pop, q_full, q_empty;
  result_t      res;
  logic         res_valid;

  always_comb begin
    transpose_nxt = transpose_r;
    tolerance_nxt = tolerance_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_TRANSPOSE: transpose_nxt = $signed(cfg_data);
        REG_TOLERANCE: tolerance_nxt = cfg_data[5:0];
        default:       transpose_nxt = transpose_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transpose_r <= 7'sd0;
      tolerance_r <= 6'd2;
    end else begin
      transpose_r <= transpose_nxt;
      tolerance_r <= tolerance_nxt;
    end
  end

  // The front end classifies each word and drops loads beyond the table.
  tednl_front #(.NOTE_COUNT(NOTE_COUNT)) u_front (
    .in_bus (in_bus),
    .q_full (q_full),
    .q_data (push_data),
    .q_push (q_push)
  );

  // Words stay in order through the queue, so a load always lands before
  // any decode that follows it.
  tednl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tednl_back #(.NOTE_COUNT(NOTE_COUNT)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .transpose       (transpose_r),
    .match_tolerance (tolerance_r),
    .res             (res),
    .res_valid       (res_valid),
    .res_ready       (out_bus.ready)
  );

  assign out_bus.valid          = res_valid;
  assign out_bus.instrument_num = res.instrument_num;
  assign out_bus.effect_code    = res.effect_code;
  assign out_bus.effect_param   = res.effect_param;
  assign out_bus.period         = res.period;
  assign out_bus.note_status    = res.note_status;
  assign out_bus.note_index     = res.note_index;

endmodule

`default_nettype wire

// ----- design/tednl_checker.sv -----
// Port-level checker for the tracker event decoder, bound to the top level.
// Depends on tednl_pkg and tracker_event_decode_note_lookup_macros.svh.
`default_nettype none
`include "tracker_event_decode_note_lookup_macros.svh"

module tednl_checker
  import tednl_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [4:0]        instrument_num,
  input wire logic [3:0]        effect_code,
  input wire logic [7:0]        effect_param,
  input wire logic [11:0]       period,
  input wire logic [1:0]        note_status,
  input wire logic signed [7:0] note_index
);

  logic [38:0] payload;
  logic        stalled;
  logic        no_note;
  logic        zero_match;

  assign payload    = {instrument_num, effect_code, effect_param, period,
                       note_status, note_index};
  assign stalled    = out_valid && !out_ready;
  assign no_note    = out_valid && (note_status != NOTE_FOUND);
  assign zero_match = (period == 12'd0) == (note_status == NOTE_ZERO);

  `TEDNL_ASSERT_NEXT(a_valid_holds, stalled, out_valid, "result word dropped while stalled")
  `TEDNL_ASSERT_NEXT(a_payload_holds, stalled, $stable(payload), "result word changed")
  `TEDNL_ASSERT_NOW(a_status_legal, out_valid, note_status <= NOTE_NOMATCH, "illegal status")
  `TEDNL_ASSERT_NOW(a_index_zero, no_note, note_index == 8'sd0, "stray note index")
  `TEDNL_ASSERT_NOW(a_zero_period, out_valid, zero_match, "period zero status mismatch")

endmodule

bind tracker_event_decode_note_lookup tednl_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .instrument_num (out_bus.instrument_num),
  .effect_code    (out_bus.effect_code),
  .effect_param   (out_bus.effect_param),
  .period         (out_bus.period),
  .note_status    (out_bus.note_status),
  .note_index     (out_bus.note_index)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the tracker event decoder with period-to-note lookup.
// Needs tednl_pkg, the tednl_in_if and tednl_out_if interfaces and the block itself;
// expected results come from a predictor of the decode and table search kept here.
`default_nettype none

module tb_top;
  import tednl_pkg::*;

  localparam int NOTE_COUNT     = 64;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int PHASE_WORDS    = 130;

  // Receiver stall styles. Each one runs for a random stretch before the next is picked.
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_style_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [6:0] cfg_data;

  tednl_in_if  in_ch ();
  tednl_out_if out_ch ();

  tracker_event_decode_note_lookup #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_ch),
    .out_bus  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state: our own copy of the period table and of both registers. The table
  // copy is updated when a load word is accepted, the registers when they are written.
  logic [11:0] note_period [NOTE_COUNT];
  int          note_transpose;
  int          note_tolerance;

  // Results still owed by the block, oldest first.
  result_t note_expect_q [$];

  int error_count;
  int burst_left;
  bit sender_gaps_on;
  bit holdoff_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The whole run is bounded, so a hung handshake ends in a failure and not in a hang.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: done, errors");
    $finish;
  end

  // Decode one event word the way the block must: split the bytes, then look the period
  // up in the descending table. The search keeps a bracket [lo, hi] and halves it until
  // the two ends are neighbors; an exact hit on a probe ends it early. Without a hit,
  // the upper entry (larger period) wins if the period is within tolerance below it,
  // then the lower entry if the period is within tolerance above it.
  function automatic result_t predict_event(input logic [31:0] word);
    result_t r;
    int per;
    int lo;
    int hi;
    int mid;
    int probe;
    int slot;
    int note;
    bit hit;
    r.instrument_num = {word[28], word[15:12]};
    r.effect_code    = word[11:8];
    r.effect_param   = word[7:0];
    r.period         = word[27:16];
    r.note_status    = NOTE_FOUND;
    r.note_index     = '0;
    per  = int'(word[27:16]);
    lo   = 0;
    hi   = NOTE_COUNT - 1;
    slot = 0;
    hit  = 1'b0;
    if (per == 0) begin
      // A zero period means no pitch; the table is never touched.
      r.note_status = NOTE_ZERO;
    end else begin
      while (!hit && hi - lo > 1) begin
        mid   = (lo + hi) / 2;
        probe = int'(note_period[mid]);
        if (probe == per) begin
          hit  = 1'b1;
          slot = mid;
        end else if (probe > per) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      if (!hit) begin
        if (int'(note_period[lo]) - note_tolerance <= per) begin
          slot = lo;
        end else if (int'(note_period[hi]) + note_tolerance >= per) begin
          slot = hi;
        end else begin
          r.note_status = NOTE_NOMATCH;
        end
      end
      if (r.note_status == NOTE_FOUND) begin
        // The sum saturates to the signed 8-bit range; with 64 entries it never gets there.
        note = slot + note_transpose;
        if (note > 127) note = 127;
        if (note < -128) note = -128;
        r.note_index = 8'(note);
      end
    end
    return r;
  endfunction

  // Build an event word around a given period, with random sample and effect bytes.
  function automatic logic [31:0] event_with_period(input int per);
    logic [3:0]  b0_high;
    logic [15:0] tail;
    b0_high = 4'($urandom_range(0, 15));
    tail    = 16'($urandom);
    return {b0_high, 12'(per), tail};
  endfunction

  // Pick a period that lands somewhere interesting in the current table: zero, an exact
  // entry, just inside or just outside the tolerance window, halfway between neighbors,
  // or anywhere at all.
  function automatic int pick_period();
    int sel;
    int k;
    int p;
    sel = $urandom_range(0, 99);
    k   = $urandom_range(0, NOTE_COUNT - 2);
    if (sel < 8) begin
      p = 0;
    end else if (sel < 28) begin
      p = int'(note_period[k + $urandom_range(0, 1)]);
    end else if (sel < 68) begin
      p = int'(note_period[k]) + int'($urandom_range(0, 2 * note_tolerance + 6))
          - (note_tolerance + 3);
    end else if (sel < 80) begin
      p = (int'(note_period[k]) + int'(note_period[k + 1])) / 2;
    end else begin
      p = $urandom_range(0, 4095);
    end
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return p;
  endfunction

  // Offer one word and hold it until the block takes it. The sender works in bursts;
  // when a burst runs out it may first drop valid for a random gap. Once the word is
  // accepted, the predictor sees it at that same edge.
  task automatic send_word(input logic mode_i, input logic [5:0] idx_i,
                           input logic [11:0] per_i, input logic [31:0] word_i);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = (sender_gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode_i;
    in_ch.table_index  <= idx_i;
    in_ch.table_period <= per_i;
    in_ch.event_word   <= word_i;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (mode_i == MODE_DECODE) begin
      note_expect_q.push_back(predict_event(word_i));
    end else begin
      note_period[idx_i] = per_i;
    end
  endtask

  task automatic send_decode(input logic [31:0] word);
    send_word(MODE_DECODE, 6'($urandom), 12'($urandom), word);
  endtask

  task automatic send_load(input int idx, input int per);
    send_word(MODE_LOAD, 6'(idx), 12'(per), $urandom);
  endtask

  // Bring the block to rest: stop offering words, wait for every owed result, then give
  // the back end time to finish any load that is still queued behind the last result.
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (note_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_TRANSPOSE) begin
      note_transpose = int'($signed(data));
    end else begin
      note_tolerance = int'(data[5:0]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // The tolerance register is 6 bits wide, so the spare top data bit is random.
  task automatic program_registers(input int transpose_val, input int tolerance_val);
    write_reg(REG_TRANSPOSE, 7'(transpose_val));
    write_reg(REG_TOLERANCE, {1'($urandom_range(0, 1)), 6'(tolerance_val)});
  endtask

  // Load a full, strictly descending table that starts at the given period. Steps are
  // random, but never so large that the remaining entries could not stay positive.
  // Optionally the last entry is set to zero. Entries go in ascending or descending
  // index order.
  task automatic load_period_table(input int top, input bit zero_last);
    int fresh [NOTE_COUNT];
    int gap_max;
    int gap;
    int i;
    bit upward;
    gap_max  = (top / 32 > 1) ? top / 32 : 1;
    fresh[0] = top;
    for (i = 1; i < NOTE_COUNT; i++) begin
      gap = $urandom_range(1, gap_max);
      if (fresh[i - 1] - gap < NOTE_COUNT - i) gap = 1;
      fresh[i] = fresh[i - 1] - gap;
    end
    if (zero_last) fresh[NOTE_COUNT - 1] = 0;
    upward = $urandom_range(0, 1);
    for (i = 0; i < NOTE_COUNT; i++) begin
      if (upward) begin
        send_load(i, fresh[i]);
      end else begin
        send_load(NOTE_COUNT - 1 - i, fresh[NOTE_COUNT - 1 - i]);
      end
    end
  endtask

  // Mostly decodes aimed at the table, with some table rewrites mixed in. Half of the
  // rewrites keep the table in order; the rest put an arbitrary period anywhere, which
  // the search must then handle exactly as it does an ordered table.
  task automatic run_traffic(input int count);
    int n;
    int idx;
    int upper;
    int lower;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 8) begin
        idx = $urandom_range(0, NOTE_COUNT - 1);
        if ($urandom_range(0, 1) == 1) begin
          send_load(idx, $urandom_range(0, 4095));
        end else begin
          upper = (idx == 0) ? 4095 : int'(note_period[idx - 1]);
          lower = (idx == NOTE_COUNT - 1) ? 0 : int'(note_period[idx + 1]);
          send_load(idx, $urandom_range(lower, upper));
        end
      end else begin
        send_decode(event_with_period(pick_period()));
      end
    end
  endtask

  // A zero period never reads the table, so it is the one decode that is legal before
  // any entry has been loaded.
  task automatic test_zero_before_load();
    send_decode(32'h0000_0000);
  endtask

  task automatic test_table_load();
    load_period_table(4095, 1'b0);
  endtask

  // Directed events at the reset register values: field extremes, exact hits at the
  // first probe, at deep probes and at both table ends, a period below the last entry,
  // and both edges of the tolerance window around the widest gap in the table.
  task automatic test_directed_events();
    int k;
    int widest;
    int i;
    int hi_per;
    int lo_per;
    send_decode(32'hFFFF_FFFF);
    send_decode(32'hF000_5AA5);
    send_decode(event_with_period(int'(note_period[31])));
    send_decode(event_with_period(int'(note_period[15])));
    send_decode(event_with_period(int'(note_period[47])));
    send_decode(event_with_period(int'(note_period[1])));
    send_decode(event_with_period(int'(note_period[62])));
    send_decode(event_with_period(int'(note_period[0])));
    send_decode(event_with_period(int'(note_period[NOTE_COUNT - 1])));
    send_decode(event_with_period(int'(note_period[NOTE_COUNT - 1]) - 1));
    send_decode(event_with_period(1));
    k = 0;
    widest = 0;
    for (i = 0; i < NOTE_COUNT - 1; i++) begin
      if (int'(note_period[i]) - int'(note_period[i + 1]) > widest) begin
        widest = int'(note_period[i]) - int'(note_period[i + 1]);
        k = i;
      end
    end
    hi_per = int'(note_period[k]);
    lo_per = int'(note_period[k + 1]);
    send_decode(event_with_period(hi_per - note_tolerance));
    send_decode(event_with_period(hi_per - note_tolerance - 1));
    send_decode(event_with_period(lo_per + note_tolerance));
    send_decode(event_with_period(lo_per + note_tolerance + 1));
    send_decode(event_with_period((hi_per + lo_per) / 2));
  endtask

  task automatic test_default_registers();
    run_traffic(PHASE_WORDS);
  endtask

  // Register settings from one extreme to the other, each with a fresh table. The wide
  // tolerance runs against a table with a zero bottom entry; the small transpose runs
  // against a cramped table whose top is low, so periods above it are common.
  task automatic test_register_sweep();
    int phase;
    int top;
    bit zero_last;
    for (phase = 0; phase < 5; phase++) begin
      settle_block();
      zero_last = 1'b0;
      case (phase)
        0: begin
          program_registers(-63, 0);
          top = $urandom_range(300, 4095);
        end
        1: begin
          program_registers(63, 63);
          top = 4095;
          zero_last = 1'b1;
        end
        2: begin
          program_registers(-1, 1);
          top = $urandom_range(64, 200);
        end
        default: begin
          program_registers(int'($urandom_range(0, 126)) - 63, $urandom_range(0, 63));
          top = $urandom_range(64, 4095);
        end
      endcase
      load_period_table(top, zero_last);
      run_traffic(PHASE_WORDS);
    end
  endtask

  // The receiver refuses results for a long stretch while the sender keeps offering
  // words without pause, so the queue fills and the input must stall.
  task automatic test_backpressure();
    int n;
    settle_block();
    sender_gaps_on = 1'b0;
    holdoff_req = 1'b1;
    for (n = 0; n < 48; n++) begin
      send_decode(event_with_period(pick_period()));
    end
    sender_gaps_on = 1'b1;
  endtask

  // Result side ready. Outside a hold-off it follows its own pattern: always open, a coin
  // flip, mostly closed, or a fixed period, each for a random stretch.
  initial begin : result_sink
    sink_style_t style;
    int style_left;
    int period_len;
    int tick;
    int holdoff_left;
    out_ch.ready = 1'b0;
    style        = SINK_OPEN;
    style_left   = 0;
    period_len   = 2;
    tick         = 0;
    holdoff_left = 0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = sink_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(16, 160);
          period_len = $urandom_range(2, 7);
        end
        style_left--;
        tick++;
        case (style)
          SINK_OPEN:   out_ch.ready <= 1'b1;
          SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     out_ch.ready <= ((tick % period_len) != 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Every accepted result word is matched against the oldest owed result.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (note_expect_q.size() == 0) begin
        $error("result word with no decode outstanding");
        error_count++;
      end else begin
        want = note_expect_q.pop_front();
        check_field("instrument_num", want.instrument_num, out_ch.instrument_num);
        check_field("effect_code", want.effect_code, out_ch.effect_code);
        check_field("effect_param", want.effect_param, out_ch.effect_param);
        check_field("period", want.period, out_ch.period);
        check_field("note_status", want.note_status, out_ch.note_status);
        check_field("note_index", $signed(want.note_index), $signed(out_ch.note_index));
      end
    end
  end

  initial begin : test_sequence
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_TRANSPOSE;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_LOAD;
    in_ch.table_index  = '0;
    in_ch.table_period = '0;
    in_ch.event_word   = '0;
    error_count        = 0;
    burst_left         = 0;
    sender_gaps_on     = 1'b1;
    holdoff_req        = 1'b0;
    // Registers come out of reset as transpose 0 and tolerance 2; the first phases run
    // on those values without writing them.
    note_transpose     = 0;
    note_tolerance     = 2;
    foreach (note_period[i]) note_period[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_before_load();
    test_table_load();
    test_directed_events();
    test_default_registers();
    test_register_sweep();
    test_backpressure();
    settle_block();

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
